// ===== rtl/nhfi_pkg.sv =====
// ----------------------------------------------------------------------------
// nhfi_pkg
// Shared types, constants and the djb2 fold for the name hash registry.
// ----------------------------------------------------------------------------
`default_nettype none

package nhfi_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam logic [31:0] HASH_START      = 32'd5381;
    localparam int unsigned HASH_SHIFT      = 5;

    // Stream widths: tdata fields packed from bit 0, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 72;   // name_byte[7:0], entry_value[71:8]
    localparam int unsigned OUT_TDATA_W = 48;   // index, added, full, hash, pad

    // Finished name handed from the hash stage to the table
    typedef struct packed {
        logic [31:0] name_hash;
        logic [63:0] entry_value;
    } t_key_req;

    // hash * 33 + byte, wrapping at 32 bits
    function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
        fold_byte = (h << HASH_SHIFT) + h + {24'd0, b};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nhfi_hash.sv =====
// ----------------------------------------------------------------------------
// nhfi_hash
// Running djb2 hash over incoming name bytes; hands the final hash to the table.
// ----------------------------------------------------------------------------
`default_nettype none

module nhfi_hash (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [nhfi_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire                                i_s_tlast,
    output logic                               o_key_valid,
    output nhfi_pkg::t_key_req                 o_key,
    input  wire                                i_key_ready
);
    import nhfi_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] w_folded;
    logic        w_accept;

    // The table must be free to take a finished name; hold off all bytes otherwise
    assign o_s_tready = i_key_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_folded   = fold_byte(r_hash, i_s_tdata[7:0]);

    assign o_key_valid       = w_accept && i_s_tlast;
    assign o_key.name_hash   = w_folded;
    assign o_key.entry_value = i_s_tdata[71:8];

    always_comb begin
        n_hash = r_hash;
        if (w_accept) begin
            n_hash = i_s_tlast ? HASH_START : w_folded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_START;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nhfi_table.sv =====
// ----------------------------------------------------------------------------
// nhfi_table
// Hash/value memories, in-order search sequencer, append and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nhfi_table #(
    parameter int unsigned TABLE_DEPTH = nhfi_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_key_valid,
    input  nhfi_pkg::t_key_req                 i_key,
    output logic                               o_key_ready,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [nhfi_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import nhfi_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [31:0]      r_hash_mem  [TABLE_DEPTH];
    logic [63:0]      r_value_mem [TABLE_DEPTH];

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [31:0]      r_rd_data;
    t_key_req         r_key;

    logic [7:0]       r_res_idx;
    logic             r_res_added;
    logic             r_res_full;

    logic             r_out_valid;
    logic [7:0]       r_out_idx;
    logic             r_out_added;
    logic             r_out_full;
    logic [31:0]      r_out_hash;

    logic             w_issue;
    logic             w_hit;
    logic             w_miss;
    logic             w_room;
    logic             w_insert;
    logic             w_load_out;
    logic [IDX_W+7:0] w_cmp_ext;
    logic [CNT_W+7:0] w_cnt_ext;

    assign o_key_ready = (r_state == S_IDLE);

    assign w_issue  = (r_state == S_SEARCH) && (r_rd_idx < r_count);
    assign w_hit    = (r_state == S_SEARCH) && r_cmp_vld && (r_rd_data == r_key.name_hash);
    // Last read's compare lands when the issue pointer has reached the count
    assign w_miss   = (r_state == S_SEARCH) && !w_hit && (r_rd_idx == r_count);
    assign w_room   = (r_count < CNT_W'(TABLE_DEPTH));
    assign w_insert = w_miss && w_room;

    assign w_load_out = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    assign w_cmp_ext = {8'd0, r_cmp_idx};
    assign w_cnt_ext = {8'd0, r_count};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_key_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_hit || w_miss) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memories: one write port (append), one registered read port (search)
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_hash_mem[r_count[IDX_W-1:0]]  <= r_key.name_hash;
            r_value_mem[r_count[IDX_W-1:0]] <= r_key.entry_value;
        end
        if (w_issue) begin
            r_rd_data <= r_hash_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue;
            if (w_insert) begin
                r_count <= r_count + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_key_valid) begin
            r_key    <= i_key;
            r_rd_idx <= '0;
        end else if (w_issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (w_issue) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (w_hit) begin
            r_res_idx   <= w_cmp_ext[7:0];
            r_res_added <= 1'b0;
            r_res_full  <= 1'b0;
        end else if (w_miss) begin
            r_res_idx   <= w_room ? w_cnt_ext[7:0] : 8'd0;
            r_res_added <= w_room;
            r_res_full  <= !w_room;
        end
        if (w_load_out) begin
            r_out_idx   <= r_res_idx;
            r_out_added <= r_res_added;
            r_out_full  <= r_res_full;
            r_out_hash  <= r_key.name_hash;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_hash, r_out_full, r_out_added, r_out_idx};

endmodule

`default_nettype wire

// ===== rtl/name_hash_find_or_insert.sv =====
// ----------------------------------------------------------------------------
// name_hash_find_or_insert
// djb2 name registry: hash a name byte by byte, then find or append it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one name byte per request, tlast on the final byte,
//   entry_value in the upper tdata bits (only used on the tlast request).
//   Bytes are accepted while the table is idle. A tlast request starts a
//   search of the stored hashes in insertion order, one memory read per
//   cycle through the single hash memory port. The search stops at the
//   first hit or after the last stored hash is compared; the result is
//   then loaded into the output register once that is free, and the next
//   byte can be taken. A miss appends the hash and value if there is room,
//   else reports table_full with index 0.
//   One result per name leaves on the master stream from an output
//   register; s_tready stays low from the last byte until the result is
//   loaded there. If the receiver stalls, the result waits; the next name
//   still streams in and is searched, and its result then holds in the
//   table with s_tready low until the output register frees.
//   Reset (synchronous, active low) empties the table and restarts the hash
//   at 5381; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module name_hash_find_or_insert #(
    parameter int unsigned TABLE_DEPTH = nhfi_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [nhfi_pkg::IN_TDATA_W-1:0]    s_tdata,   // name_byte[7:0], entry_value[71:8]
    input  wire                                s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [nhfi_pkg::OUT_TDATA_W-1:0]   m_tdata    // entry_index[7:0], newly_added[8],
                                                          // table_full[9], name_hash[41:10]
);
    import nhfi_pkg::*;

    logic     w_key_valid;
    logic     w_key_ready;
    t_key_req w_key;

    nhfi_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_key_valid (w_key_valid),
        .o_key       (w_key),
        .i_key_ready (w_key_ready)
    );

    nhfi_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (w_key_valid),
        .i_key       (w_key),
        .o_key_ready (w_key_ready),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    a_added_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
        else $error("result both added and full");

    a_full_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[9]) |-> (m_tdata[7:0] == 8'd0))
        else $error("full result with nonzero index");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken while a search is pending");

    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a search");

endmodule

`default_nettype wire
